>>> hdl/rsi_pkg.sv
// Package for the ray/sphere intersection unit: widths, register indexes,
// payload types. No dependencies.
package rsi_pkg;

  localparam int CoordW   = 16;
  localparam int DistW    = 24;
  localparam int RadiusW  = 15;
  localparam int DirFrac  = 14;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] RegCenterX = 2'd0;
  localparam logic [CfgAddrW-1:0] RegCenterY = 2'd1;
  localparam logic [CfgAddrW-1:0] RegCenterZ = 2'd2;
  localparam logic [CfgAddrW-1:0] RegRadius  = 2'd3;

  localparam logic [RadiusW-1:0] RadiusReset = 15'd256;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DistW-1:0] distance;
  } result_t;

endpackage

>>> hdl/rsi_if.sv
// Valid/ready stream interfaces for rays and results.
// Depends on rsi_pkg.
interface rsi_ray_if (input logic clk);
  logic           valid;
  logic           ready;
  rsi_pkg::ray_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsi_result_if (input logic clk);
  logic             valid;
  logic             ready;
  rsi_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/rsi_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage (22 stages).
// Depends on rsi_pkg.
module rsi_sqrt_pipe (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [43:0]               in_arg,
  input  logic signed [19:0]        in_tca,
  input  logic                      in_hit,
  output logic                      out_valid,
  output logic [21:0]               out_root,
  output logic signed [19:0]        out_tca,
  output logic                      out_hit
);
  import rsi_pkg::*;

  localparam int Steps = 22;

  logic                 vld  [Steps+1];
  logic [43:0]          rem  [Steps+1];
  logic [21:0]          res  [Steps+1];
  logic signed [19:0]   tca  [Steps+1];
  logic                 hitp [Steps+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_arg;
  assign res[0]  = '0;
  assign tca[0]  = in_tca;
  assign hitp[0] = in_hit;

  // One restoring digit per stage, MSB first
  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [43:0] trial;
    logic [43:0] part;
    always_comb begin
      part  = rem[s] >> (2 * (Steps - 1 - s));
      trial = {20'd0, res[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
      if (en) begin
        tca[s+1]  <= tca[s];
        hitp[s+1] <= hitp[s];
        if (part >= trial) begin
          rem[s+1] <= rem[s] - (trial << (2 * (Steps - 1 - s)));
          res[s+1] <= {res[s][20:0], 1'b1};
        end else begin
          rem[s+1] <= rem[s];
          res[s+1] <= {res[s][20:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[Steps];
  assign out_root  = res[Steps];
  assign out_tca   = tca[Steps];
  assign out_hit   = hitp[Steps];
endmodule

>>> hdl/ray_sphere_intersection_unit.sv
// Ray/sphere intersection unit: top level, front end arithmetic and output.
// Depends on rsi_pkg, rsi_if and rsi_sqrt_pipe.
// Throughput: one ray per cycle; the pipeline advances as one unit when the
// result register is empty or being taken. Square root takes 22 stages.
// Reset (synchronous, rst high) clears all valid bits and sets center 0,
// radius RadiusReset (256).
module ray_sphere_intersection_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rsi_pkg::CfgAddrW-1:0]  cfg_index,
  input  logic [rsi_pkg::CfgDataW-1:0]  cfg_data,
  rsi_ray_if.sink                       ray,
  rsi_result_if.source                  result
);
  import rsi_pkg::*;

  logic signed [CoordW-1:0]  center_x, center_y, center_z;
  logic [RadiusW-1:0]        radius;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      radius   <= RadiusReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCenterX: center_x <= cfg_data;
        RegCenterY: center_y <= cfg_data;
        RegCenterZ: center_z <= cfg_data;
        RegRadius:  radius   <= cfg_data[RadiusW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic sq_valid;
  assign en        = !result.valid || result.ready;
  assign ray.ready = en;

  // Stage 1: L = C - O, keep D
  logic               v1;
  logic signed [16:0] lx1, ly1, lz1;
  logic signed [15:0] dx1, dy1, dz1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= ray.valid;
    if (en) begin
      lx1 <= 17'(center_x) - 17'(ray.data.origin_x);
      ly1 <= 17'(center_y) - 17'(ray.data.origin_y);
      lz1 <= 17'(center_z) - 17'(ray.data.origin_z);
      dx1 <= ray.data.dir_x;
      dy1 <= ray.data.dir_y;
      dz1 <= ray.data.dir_z;
    end
  end

  // Stage 2: products
  logic               v2;
  logic signed [32:0] px2, py2, pz2;
  logic [33:0]        qx2, qy2, qz2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      px2 <= 33'(lx1 * dx1);
      py2 <= 33'(ly1 * dy1);
      pz2 <= 33'(lz1 * dz1);
      qx2 <= 34'(lx1 * lx1);
      qy2 <= 34'(ly1 * ly1);
      qz2 <= 34'(lz1 * lz1);
    end
  end

  // Stage 3: sums, round tca, r*r
  logic               v3;
  logic signed [19:0] tca3;
  logic [35:0]        ll3;
  logic [29:0]        r23;
  logic signed [34:0] dot3;
  always_comb dot3 = 35'(px2) + 35'(py2) + 35'(pz2) + 35'sd8192;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      tca3 <= 20'(dot3 >>> DirFrac);
      ll3  <= 36'(qx2) + 36'(qy2) + 36'(qz2);
      r23  <= 30'(radius * radius);
    end
  end

  // Stage 4: tca squared
  logic               v4;
  logic signed [19:0] tca4;
  logic [35:0]        ll4;
  logic [29:0]        r24;
  logic [37:0]        t24;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      tca4 <= tca3;
      ll4  <= ll3;
      r24  <= r23;
      t24  <= 38'(tca3 * tca3);
    end
  end

  // Stage 5: hit test and root operand
  logic               v5;
  logic signed [19:0] tca5;
  logic               hit5;
  logic [43:0]        arg5;
  logic signed [39:0] d2, diff;
  logic               h;
  always_comb begin
    d2   = 40'(ll4) - 40'(t24);
    diff = 40'(r24) - d2;
    h    = (tca4 <= 0) ? (40'(ll4) <= 40'(r24)) : (d2 <= $signed(40'(r24)));
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      tca5 <= tca4;
      hit5 <= h;
      arg5 <= (diff < 0) ? '0 : 44'(diff);
    end
  end

  logic [21:0]        root;
  logic signed [19:0] tca_s;
  logic               hit_s;
  rsi_sqrt_pipe u_sqrt (
    .clk, .rst, .en,
    .in_valid(v5), .in_arg(arg5), .in_tca(tca5), .in_hit(hit5),
    .out_valid(sq_valid), .out_root(root), .out_tca(tca_s), .out_hit(hit_s)
  );

  // Output register: distance select, zero distance on a miss
  logic signed [23:0] dsel;
  logic signed [23:0] dm, dp;
  always_comb begin
    dm   = 24'(tca_s) - 24'({2'b0, root});
    dp   = 24'(tca_s) + 24'({2'b0, root});
    dsel = (dm < 0) ? dp : dm;
  end
  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (en) result.valid <= sq_valid;
    if (en) begin
      result.data.hit      <= hit_s;
      result.data.distance <= hit_s ? dsel : '0;
    end
  end

  // A held result must not change while stalled
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> $stable(result.data))
    else $error("result changed under stall");
  // A miss always carries zero distance
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.hit |-> result.data.distance == '0)
    else $error("miss with nonzero distance");
  // Ready follows the output register state
  assert property (@(posedge clk) disable iff (rst)
    ray.ready == (!result.valid || result.ready))
    else $error("ready mismatch");
endmodule
